/* rtl/binary_bcd_converter_macros.svh */
// Assertion macros shared by the converter RTL.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef BINARY_BCD_CONVERTER_MACROS_SVH
`define BINARY_BCD_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BBC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BBC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, constants and step functions for the binary/BCD converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

  localparam int DataW           = 32;
  localparam int BcdW            = 40;   // ten digits hold any 32-bit value
  localparam int NumNibbles      = 8;
  localparam int NumBcdDigits    = 10;
  localparam int NumStages       = 8;    // one BCD digit or four binary bits per stage
  localparam int BinBitsPerStage = 4;    // 32 binary bits over 8 stages

  typedef enum logic {
    ACT_BIN2BCD = 1'b0,
    ACT_BCD2BIN = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2
  } width_mode_e;

  // Input item
  typedef struct packed {
    logic        action;
    logic [1:0]  width_mode;
    logic [31:0] value;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [31:0] result;
    logic        error;
  } rsp_t;

  // Work carried between pipeline stages
  typedef struct packed {
    logic            action;
    logic [3:0]      digits;
    logic            bad;      // invalid BCD nibble seen at entry
    logic [DataW-1:0] val;     // input bits not yet consumed, MSB first
    logic [BcdW-1:0] acc;      // BCD digits or binary accumulator
  } pipe_t;

  // Binary input mask for each width mode; the unused code acts as 32 bits
  function automatic logic [DataW-1:0] bit_mask(logic [1:0] mode);
    logic [DataW-1:0] m;
    case (width_mode_e'(mode))
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Ones over the low 'digits' nibbles
  function automatic logic [DataW-1:0] nibble_mask(logic [3:0] digits);
    logic [DataW-1:0] m;
    m = '0;
    for (int i = 0; i < NumNibbles; i++) begin
      if (4'(i) < digits) begin
        m[i*4 +: 4] = 4'hF;
      end
    end
    return m;
  endfunction

  // One pipeline stage of work: four double-dabble shifts, or one BCD digit
  function automatic pipe_t bbc_step(pipe_t p);
    pipe_t                 q;
    logic [BcdW+DataW-1:0] sh;
    q  = p;
    sh = {p.acc, p.val};
    if (p.action == ACT_BIN2BCD) begin
      for (int s = 0; s < BinBitsPerStage; s++) begin
        // add 3 to every digit of 5 or more, then shift one bit in
        for (int d = 0; d < NumBcdDigits; d++) begin
          if (sh[DataW + d*4 +: 4] >= 4'd5) begin
            sh[DataW + d*4 +: 4] = sh[DataW + d*4 +: 4] + 4'd3;
          end
        end
        sh = sh << 1;
      end
      q.acc = sh[BcdW+DataW-1:DataW];
      q.val = sh[DataW-1:0];
    end else begin
      // acc = acc * 10 + top nibble
      q.acc = (p.acc << 3) + (p.acc << 1) + {{(BcdW-4){1'b0}}, p.val[DataW-1 -: 4]};
      q.val = {p.val[DataW-5:0], 4'h0};
    end
    return q;
  endfunction

endpackage

`default_nettype wire

/* rtl/binary_bcd_converter.sv */
// An accepted item passes the entry register, the eight conversion stages
//   (one BCD digit or four binary bits each) and the output register; done
//   is high for one cycle with its result.
// Throughput: one item per cycle; busy is low whenever rst is low.
//   Reset empties the pipeline.
// ----------------------------------------------------------------------------
// binary_bcd_converter
// Pipelined binary to packed BCD and packed BCD to binary converter.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_bcd_converter #(
  parameter int MAX_DIGITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire bbc_pkg::cmd_t cmd,
  output logic               done,
  output bbc_pkg::rsp_t      rsp
);
  import bbc_pkg::*;

`include "binary_bcd_converter_macros.svh"

  localparam int CapDigits = (MAX_DIGITS < NumNibbles) ? MAX_DIGITS : NumNibbles;
  localparam int Latency   = NumStages + 2;

  logic             accept;
  logic [3:0]       in_digits;
  logic [DataW-1:0] in_nmask;
  logic [DataW-1:0] bcd_word;
  logic             in_bad;
  pipe_t            pipe0_next;

  logic             stg_valid [0:NumStages];
  pipe_t            stg_data  [0:NumStages];

  logic [DataW-1:0] out_nmask;
  rsp_t             rsp_next;
  logic             out_act;
  logic             rsp_digits_ok;

  // Digit count of a width mode, capped by MAX_DIGITS
  function automatic logic [3:0] digit_count(logic [1:0] mode);
    logic [3:0] d;
    case (width_mode_e'(mode))
      WIDTH_8:  d = 4'd2;
      WIDTH_16: d = 4'd4;
      default:  d = 4'd8;
    endcase
    if (d > 4'(CapDigits)) begin
      d = 4'(CapDigits);
    end
    return d;
  endfunction

  // no stall: items are taken every cycle outside reset
  assign busy   = rst;
  assign accept = start && !busy;

  // entry: masking and BCD nibble check
  always_comb begin
    in_digits = digit_count(cmd.width_mode);
    in_nmask  = nibble_mask(in_digits);
    bcd_word  = cmd.value & in_nmask;
    in_bad    = 1'b0;
    for (int i = 0; i < NumNibbles; i++) begin
      if (in_nmask[i*4] && (bcd_word[i*4 +: 4] > 4'd9)) begin
        in_bad = 1'b1;
      end
    end
    pipe0_next.action = cmd.action;
    pipe0_next.digits = in_digits;
    pipe0_next.bad    = in_bad;
    pipe0_next.val    = (cmd.action == ACT_BCD2BIN) ? bcd_word
                                                   : (cmd.value & bit_mask(cmd.width_mode));
    pipe0_next.acc    = '0;
  end

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else begin
      stg_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stg_data[0] <= pipe0_next;
  end

  // conversion stages
  for (genvar k = 1; k <= NumStages; k++) begin : g_stage
    bbc_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stg_valid[k-1]),
      .in_data  (stg_data[k-1]),
      .out_valid(stg_valid[k]),
      .out_data (stg_data[k])
    );
  end

  // final digit select and error
  always_comb begin
    out_nmask = nibble_mask(stg_data[NumStages].digits);
    if (stg_data[NumStages].action == ACT_BIN2BCD) begin
      rsp_next.result = stg_data[NumStages].acc[DataW-1:0] & out_nmask;
      rsp_next.error  = |(stg_data[NumStages].acc & ~{{(BcdW-DataW){1'b0}}, out_nmask});
    end else if (stg_data[NumStages].bad) begin
      rsp_next.result = '0;
      rsp_next.error  = 1'b1;
    end else begin
      rsp_next.result = stg_data[NumStages].acc[DataW-1:0];
      rsp_next.error  = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stg_valid[NumStages];
    end
  end

  always_ff @(posedge clk) begin
    rsp     <= rsp_next;
    out_act <= stg_data[NumStages].action;
  end

  // every result nibble is a decimal digit
  always_comb begin
    rsp_digits_ok = 1'b1;
    for (int i = 0; i < NumNibbles; i++) begin
      if (rsp.result[i*4 +: 4] > 4'd9) begin
        rsp_digits_ok = 1'b0;
      end
    end
  end

  // checks
  `BBC_ASSERT_IMP(a_done_after_accept, clk, rst, done, $past(accept, Latency), "result without item")
  `BBC_ASSERT_NXT(a_last_stage_done, clk, rst, stg_valid[NumStages], done, "item lost at output")
  `BBC_ASSERT_IMP(a_bcd_err_zero, clk, rst, done && (out_act == ACT_BCD2BIN) && rsp.error, rsp.result == '0, "BCD error with nonzero result")
  `BBC_ASSERT_IMP(a_bin_digits, clk, rst, done && (out_act == ACT_BIN2BCD), rsp_digits_ok, "BCD output digit above 9")

endmodule

`default_nettype wire

/* rtl/bbc_stage.sv */
// ----------------------------------------------------------------------------
// bbc_stage
// One register stage of the conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire bbc_pkg::pipe_t in_data,
  output logic                out_valid,
  output bbc_pkg::pipe_t      out_data
);
  import bbc_pkg::*;

  pipe_t data_next;

  // stage work
  always_comb begin
    data_next = bbc_step(in_data);
  end

  // valid bit, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

`default_nettype wire
